// ===== hdl/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros shared by the hasher's modules.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SHA_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rstn, prop, msg)
`define SHA_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hdl/sha256_pkg.sv =====
package sha256_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } core_state_e;

  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    unique case (i)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sha256_fifo.sv =====
`include "sha256_byte_stream_hasher_assert.svh"
// Small request queue between the input side and the hashing core.
module sha256_fifo #(
  parameter int unsigned Depth = sha256_pkg::FifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha256_pkg::in_req_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output sha256_pkg::in_req_t rdata_o,
  output logic               empty_o
);
  import sha256_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_req_t              mem_q [Depth];
  logic    [Aw-1:0]     wptr_q, rptr_q;
  logic    [Aw:0]       cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

  `SHA_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > (Aw+1)'(Depth), "queue count overflow")
  `SHA_ASSERT(a_push_grow, clk_i, rst_ni, (do_push && !do_pop) |=> !empty_o, "push lost")
  `SHA_ASSERT(a_pop_drop, clk_i, rst_ni, (do_pop && !do_push) |=> !full_o, "pop lost")

endmodule

// ===== hdl/sha256_core.sv =====
`include "sha256_byte_stream_hasher_assert.svh"
// Sequencer: buffers bytes, pads, runs one round per cycle, emits the digest.
module sha256_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  sha256_pkg::in_req_t  req_i,
  output logic                 req_take_o,
  output logic                 out_valid_o,
  output sha256_pkg::out_req_t out_o,
  input  logic                 out_take_i
);
  import sha256_pkg::*;

  core_state_e      state_q, state_d;
  logic [7:0]       blk_mem [64];
  logic [5:0]       fill_q;
  logic [63:0]      bits_q;
  logic [31:0]      h_q [8];
  logic [31:0]      v_q [8];
  logic [31:0]      w_q [16];
  logic [5:0]       cnt_q;
  logic [2:0]       widx_q;
  logic             fin_q;      // finishing a message
  logic             second_q;   // length still needs its own block
  logic             lenblk_q;   // block in flight carries the length
  logic [5:0]       pad_pos_q;  // position of the 0x80 byte
  logic [7:0]       rd_q;
  logic             wr_en;
  logic [5:0]       wr_addr;
  logic [7:0]       wr_data;
  logic [5:0]       rd_addr;
  logic [7:0]       ld_byte;
  logic [31:0]      wt, s0, s1, e1, e0, ch, maj, t1, t2;
  logic             is_fin;

  assign is_fin = (req_i.op == OP_FINISH);

  // Byte memory: written only by absorbed bytes, read one address a cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      blk_mem[wr_addr] <= wr_data;
    end
    rd_q <= blk_mem[rd_addr];
  end

  assign wr_en   = (state_q == ST_IDLE) && req_valid_i && !is_fin;
  assign wr_addr = fill_q;
  assign wr_data = req_i.data_byte;

  // Load phase reads byte cnt_q+1 ahead; cnt 0 is prefetched in the idle or fold state.
  assign rd_addr = (state_q == ST_LOAD) ? cnt_q + 6'd1 : 6'd0;

  // Padding overlays the stored bytes for the byte at position cnt_q.
  always_comb begin
    if (!fin_q) begin
      ld_byte = rd_q;
    end else if (lenblk_q && cnt_q >= LenPos) begin
      ld_byte = bits_q[8*(7 - (cnt_q - LenPos)) +: 8];
    end else if (second_q == 1'b0 && lenblk_q == 1'b0) begin
      ld_byte = (cnt_q < pad_pos_q) ? rd_q : ((cnt_q == pad_pos_q) ? PadByte : 8'h00);
    end else if (!lenblk_q) begin
      ld_byte = (cnt_q < pad_pos_q) ? rd_q : ((cnt_q == pad_pos_q) ? PadByte : 8'h00);
    end else begin
      // length block: data and pad only if padding fits in this block
      ld_byte = (second_q) ? 8'h00 :
                ((cnt_q < pad_pos_q) ? rd_q : ((cnt_q == pad_pos_q) ? PadByte : 8'h00));
    end
  end

  // Message schedule as a 16-word sliding window.
  assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
  assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
            ^ (w_q[14] >> 10);
  assign wt = (cnt_q < 6'd16) ? w_q[cnt_q[3:0]] : w_q[0] + s0 + w_q[9] + s1;

  assign e1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
             ^ {v_q[4][24:0], v_q[4][31:25]};
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + e1 + ch + round_k(cnt_q) + wt;
  assign e0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
             ^ {v_q[0][21:0], v_q[0][31:22]};
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2  = e0 + maj;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (is_fin || fill_q == 6'd63) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD:  if (cnt_q == 6'd63) state_d = ST_ROUND;
      ST_ROUND: if (cnt_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (!lenblk_q) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT:  if (out_take_i && widx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_take_o  = (state_q == ST_IDLE) && req_valid_i;
    out_valid_o = (state_q == ST_EMIT);
    out_o.digest_word = h_q[widx_q];
    out_o.word_index  = widx_q;
    out_o.last_word   = (widx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      cnt_q <= '0;
      widx_q <= '0;
      fin_q <= 1'b0;
      second_q <= 1'b0;
      lenblk_q <= 1'b0;
      pad_pos_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[255-32*i -: 32];
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          widx_q <= '0;
          if (req_valid_i) begin
            if (is_fin) begin
              fin_q <= 1'b1;
              pad_pos_q <= fill_q;
              second_q <= (fill_q >= LenPos);
              lenblk_q <= (fill_q < LenPos);
            end else begin
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
            end
          end
        end
        ST_LOAD: begin
          w_q[cnt_q[5:2]] <= {w_q[cnt_q[5:2]][23:0], ld_byte};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          end
        end
        ST_ROUND: begin
          if (cnt_q >= 6'd16) begin
            for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
            w_q[15] <= wt;
          end else if (cnt_q == 6'd15) begin
            // window now starts at word 0 for round 16
          end
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          cnt_q <= cnt_q + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          cnt_q <= '0;
          fill_q <= '0;
          if (fin_q && !lenblk_q) begin
            lenblk_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_take_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitHash[255-32*i -: 32];
              fin_q <= 1'b0;
              lenblk_q <= 1'b0;
              second_q <= 1'b0;
              bits_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `SHA_ASSERT(a_emit_wrap, clk_i, rst_ni,
    (state_q == ST_EMIT && out_take_i && widx_q == 3'd7) |=> state_q == ST_IDLE,
    "digest did not end")
  `SHA_NEVER(a_take_busy, clk_i, rst_ni, req_take_o && state_q != ST_IDLE, "take while busy")
  `SHA_ASSERT(a_fold_after, clk_i, rst_ni,
    (state_q == ST_ROUND && cnt_q == 6'd63) |=> state_q == ST_FOLD, "rounds overran")

endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream.
// Input queue: push with in_i (op, data_byte), accepted when push is high and
// full is low. Op absorb adds one message byte; op finish pads the message and
// produces the digest. A two-entry queue sits in front of the hashing core.
// Output side: while empty is low, out_o holds the next digest word; pop
// takes it. Eight words come per finish, most significant first, with last_word
// set on the eighth.
// Timing: a byte that does not complete a block is only written to the byte memory. The
// 64th byte starts a compression: a load phase, a round phase and one fold. Its pace is
// set by the single round unit and the one byte memory read port. A finish costs one or
// two such compressions, then the eight words.
// While the receiver stalls, the words stay on out_o and the core holds; the
// input queue keeps taking requests until it fills.
// Reset restores the initial hash values and clears the byte and bit counts.
module sha256_byte_stream_hasher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  sha256_pkg::in_req_t  in_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output sha256_pkg::out_req_t out_o
);
  import sha256_pkg::*;

  in_req_t q_data;
  logic    q_empty;
  logic    core_take;
  logic    core_valid;

  sha256_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_i),
    .full_o  (full),
    .pop_i   (core_take),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  sha256_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (!q_empty),
    .req_i       (q_data),
    .req_take_o  (core_take),
    .out_valid_o (core_valid),
    .out_o       (out_o),
    .out_take_i  (pop)
  );

  assign empty = !core_valid;

endmodule

// ===== verif/sha256_byte_stream_hasher_test.sv =====
`timescale 1ns / 1ps

// Checks the byte-stream SHA-256 hasher against an in-bench predictor.
// An initial block fills a queue of pending requests: directed messages first, then
// random messages. A clocked driver pushes them with random gaps, and a clocked monitor
// pops digest words with random stalls. Each popped word is compared against the
// oldest word that the predictor produced.
module sha256_byte_stream_hasher_test;
  import sha256_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  in_req_t  in_i;
  logic     full;
  logic     empty;
  logic     pop;
  out_req_t out_o;

  sha256_byte_stream_hasher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .in_i   (in_i),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Requests waiting to be pushed and digest words waiting to be popped.
  in_req_t  pending_reqs[$];
  out_req_t expected_words[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          stim_done;

  // Predictor state: the running hash, the partial block and the bit count.
  logic [31:0] run_hash[8];
  logic [7:0]  blk_bytes[64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Folds the 64 bytes in blk_bytes into run_hash.
  task automatic sha_compress();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, k;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {run_hash[0], run_hash[1], run_hash[2], run_hash[3],
                                run_hash[4], run_hash[5], run_hash[6], run_hash[7]};
    for (int i = 0; i < 64; i++) begin
      k  = round_k(i[5:0]);
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
    run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) run_hash[i] = InitHash[255 - 32*i -: 32];
    blk_fill = '0;
    msg_bits = '0;
  endtask

  // Applies one accepted request and queues any digest words it produces.
  task automatic predict_digest(in_req_t req);
    int pos;
    out_req_t word;
    if (req.op == OP_ABSORB) begin
      blk_bytes[blk_fill] = req.data_byte;
      msg_bits += 64'd8;
      blk_fill += 6'd1;
      if (blk_fill == 6'd0) sha_compress();
    end else begin
      pos = blk_fill;
      blk_bytes[pos] = PadByte;
      pos = pos + 1;
      // Long tail: the length does not fit, so an extra block carries it.
      if (pos > LenPos) begin
        for (; pos < 64; pos++) blk_bytes[pos] = 8'h00;
        sha_compress();
        pos = 0;
      end
      for (; pos < LenPos; pos++) blk_bytes[pos] = 8'h00;
      for (int i = 0; i < 8; i++) blk_bytes[56 + i] = msg_bits[63 - 8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = run_hash[i];
        word.word_index  = i[2:0];
        word.last_word   = (i == 7);
        expected_words.push_back(word);
      end
      restart_message();
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic queue_byte(logic [7:0] b);
    in_req_t r;
    r.op = OP_ABSORB;
    r.data_byte = b;
    pending_reqs.push_back(r);
  endtask

  // A finish request; its data byte is random since the block must ignore it.
  task automatic queue_finish();
    in_req_t r;
    r.op = OP_FINISH;
    r.data_byte = 8'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_message(int len, bit random_bytes, logic [7:0] fill_byte);
    for (int i = 0; i < len; i++)
      queue_byte(random_bytes ? 8'($urandom) : fill_byte);
    queue_finish();
  endtask

  // Driver: requests are pushed with random gaps between them.
  int unsigned push_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      in_i     <= '0;
      push_gap <= 0;
    end else begin
      if (push && !full) begin
        predict_digest(in_i);
        void'(pending_reqs.pop_front());
      end
      if (push && full) begin
        // Hold the current request until it is taken.
      end else if (push_gap != 0) begin
        push     <= 1'b0;
        push_gap <= push_gap - 1;
      end else if ((!push || !full) && pending_reqs.size() > ((push && !full) ? 0 : 0)
                   && stim_done) begin
        if (pending_reqs.size() != 0) begin
          push     <= 1'b1;
          in_i     <= pending_reqs[0];
          push_gap <= $urandom_range(0, 3);
        end else begin
          push <= 1'b0;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: after each pop, pop is raised again after a random stall, and each popped
  // word is checked.
  int unsigned pop_gap;
  int unsigned pop_draw;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_o));
        end else begin
          if (out_o.digest_word !== expected_words[0].digest_word)
            report_mismatch($sformatf("digest_word %h, expected %h", out_o.digest_word,
                                      expected_words[0].digest_word));
          if (out_o.word_index !== expected_words[0].word_index)
            report_mismatch($sformatf("word_index %0d, expected %0d", out_o.word_index,
                                      expected_words[0].word_index));
          if (out_o.last_word !== expected_words[0].last_word)
            report_mismatch($sformatf("last_word %b, expected %b", out_o.last_word,
                                      expected_words[0].last_word));
          void'(expected_words.pop_front());
        end
        pop_draw = $urandom_range(0, 3);
        pop_gap <= pop_draw;
        pop     <= (pop_draw == 0);
      end else if (pop_gap != 0) begin
        pop_gap <= pop_gap - 1;
        pop     <= (pop_gap == 1);
      end else begin
        pop <= 1'b1;
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    mismatch_count = 0;
    idle_cycles    = 0;
    stim_done      = 1'b0;
    restart_message();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    rst_ni = 1'b0;
    push   = 1'b0;
    pop    = 1'b0;
    in_i   = '0;

    // Directed messages: the empty message, field extremes with a finish whose data
    // byte is random, and a message that fills one block and then leaves a tail
    // that pushes the length into an extra block.
    queue_finish();
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_finish();
    queue_message(120, 1'b1, 8'h00);
    // Two short random messages.
    for (int m = 0; m < 2; m++) begin
      len = $urandom_range(0, 6);
      queue_message(len, 1'b1, 8'h00);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stim_done = 1'b1;

    while ((pending_reqs.size() != 0 || expected_words.size() != 0)
           && idle_cycles < WatchdogLimit)
      @(posedge clk_i);
    if (idle_cycles >= WatchdogLimit) begin
      $display("sha256_byte_stream_hasher verification failed");
    end else begin
      repeat (300) @(posedge clk_i);
      if (mismatch_count == 0 && expected_words.size() == 0)
        $display("sha256_byte_stream_hasher verification clean");
      else
        $display("sha256_byte_stream_hasher verification failed");
    end
    $finish;
  end
endmodule

// ===== sha256_byte_stream_hasher.f =====
+incdir+hdl
hdl/sha256_pkg.sv
hdl/sha256_fifo.sv
hdl/sha256_core.sv
hdl/sha256_byte_stream_hasher.sv
verif/sha256_byte_stream_hasher_test.sv
